/* hdl/sync_word_byte_deserializer_core_defines.svh */
// Assertion macros used by the deserializer result stage.
`ifndef SYNC_WORD_BYTE_DESERIALIZER_CORE_DEFINES_SVH
`define SYNC_WORD_BYTE_DESERIALIZER_CORE_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define SWBD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("swbd check failed");

// Next-cycle implication, checked out of reset.
`define SWBD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("swbd check failed");

`endif

/* hdl/swbd_pkg.sv */
// Shared constants and types for the sync word byte deserializer.
package swbd_pkg;

    localparam int SWBD_SYNC_WIDTH  = 16;
    localparam int SWBD_QUEUE_DEPTH = 4;
    localparam int SWBD_WORD_W      = 16;
    localparam int SWBD_BYTE_W      = 8;

    localparam logic [SWBD_WORD_W-1:0] SWBD_SYNC_RESET = 16'hABBA;
    localparam logic [2:0]             SWBD_BIT_TOP    = 3'd7;

    // One classified event: either a sync match (two result beats) or a
    // completed data byte (one result beat, held in the low byte).
    typedef struct packed {
        logic                   is_sync;
        logic [SWBD_WORD_W-1:0] data;
    } swbd_evt_t;

endpackage

/* hdl/swbd_front.sv */
// Front end: bit history, sync detection and byte assembly.
module swbd_front #(
    parameter int SYNC_WIDTH = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                sync_word_we,
    input  logic [15:0]         sync_word,
    input  logic                accept,
    input  logic                bit_in,
    output logic                evt_wr,
    output swbd_pkg::swbd_evt_t evt
);
    import swbd_pkg::*;

    localparam int CMP_W = (SYNC_WIDTH > SWBD_WORD_W) ? SYNC_WIDTH : SWBD_WORD_W;

    logic [SWBD_WORD_W-1:0] sync_word_reg;
    logic [SYNC_WIDTH-1:0]  hist_reg;
    logic [SYNC_WIDTH-1:0]  hist_next;
    logic                   locked_reg;
    logic                   locked_next;
    logic [SWBD_BYTE_W-1:0] accum_reg;
    logic [SWBD_BYTE_W-1:0] accum_next;
    logic [SWBD_BYTE_W-1:0] accum_set;
    logic [2:0]             count_reg;
    logic [2:0]             count_next;
    logic [2:0]             bit_pos;
    logic [CMP_W-1:0]       hist_ext;
    logic                   match;
    logic                   byte_done;

    always_comb
    begin
        hist_next = {hist_reg[SYNC_WIDTH-2:0], bit_in};
        hist_ext  = CMP_W'(hist_next);
        match     = (hist_ext == CMP_W'(sync_word_reg));
        bit_pos   = SWBD_BIT_TOP - count_reg;
        accum_set = accum_reg;
        accum_set[bit_pos] = accum_reg[bit_pos] | bit_in;
        byte_done = locked_reg && !match && (count_reg == SWBD_BIT_TOP);

        locked_next = locked_reg;
        accum_next  = accum_reg;
        count_next  = count_reg;
        if (match)
        begin
            locked_next = 1'b1;
            accum_next  = '0;
            count_next  = '0;
        end
        else if (byte_done)
        begin
            accum_next = '0;
            count_next = '0;
        end
        else if (locked_reg)
        begin
            accum_next = accum_set;
            count_next = count_reg + 3'd1;
        end

        evt_wr      = accept && (match || byte_done);
        evt.is_sync = match;
        evt.data    = match ? hist_ext[SWBD_WORD_W-1:0]
                            : {{(SWBD_WORD_W-SWBD_BYTE_W){1'b0}}, accum_set};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_word_reg <= SWBD_SYNC_RESET;
            hist_reg      <= '0;
            locked_reg    <= 1'b0;
            accum_reg     <= '0;
            count_reg     <= '0;
        end
        else
        begin
            if (sync_word_we)
            begin
                sync_word_reg <= sync_word;
            end
            if (accept)
            begin
                hist_reg   <= hist_next;
                locked_reg <= locked_next;
                accum_reg  <= accum_next;
                count_reg  <= count_next;
            end
        end
    end

endmodule

/* hdl/swbd_queue.sv */
// Short event queue between the front end and the result stage.
module swbd_queue #(
    parameter int DEPTH = 4
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr_en,
    input  swbd_pkg::swbd_evt_t wr_evt,
    input  logic                rd_en,
    output swbd_pkg::swbd_evt_t rd_evt,
    output logic                not_empty,
    output logic                full
);
    import swbd_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    swbd_evt_t          slots [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               do_wr;
    logic               do_rd;

    assign do_wr     = wr_en && !full;
    assign do_rd     = rd_en && not_empty;
    assign not_empty = (count_reg != '0);
    assign full      = (count_reg == CNT_W'(DEPTH));
    assign rd_evt    = slots[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slots[wr_ptr_reg] <= wr_evt;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_wr)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (do_rd)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
        end
    end

endmodule

/* hdl/swbd_back.sv */
// Result stage: expands queued events into output beats.
`include "sync_word_byte_deserializer_core_defines.svh"

module swbd_back (
    input  logic                clk,
    input  logic                rst_n,
    input  swbd_pkg::swbd_evt_t q_evt,
    input  logic                q_valid,
    output logic                q_rd,
    input  logic                pop,
    output logic                empty,
    output logic [7:0]          byte_out,
    output logic                is_sync,
    output logic                last
);
    import swbd_pkg::*;

    swbd_evt_t out_evt_reg;
    logic      out_valid_reg;
    logic      out_valid_next;
    logic      phase_reg;
    logic      phase_next;
    logic      last_beat;
    logic      pop_fire;
    logic      load;

    assign last_beat = !out_evt_reg.is_sync || phase_reg;
    assign pop_fire  = pop && out_valid_reg;
    assign load      = q_valid && (!out_valid_reg || (pop_fire && last_beat));
    assign q_rd      = load;

    assign empty    = !out_valid_reg;
    assign is_sync  = out_evt_reg.is_sync;
    assign last     = last_beat;
    assign byte_out = (out_evt_reg.is_sync && !phase_reg) ?
                      out_evt_reg.data[SWBD_WORD_W-1:SWBD_BYTE_W] :
                      out_evt_reg.data[SWBD_BYTE_W-1:0];

    always_comb
    begin
        out_valid_next = out_valid_reg;
        phase_next     = phase_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
            phase_next     = 1'b0;
        end
        else if (pop_fire && last_beat)
        begin
            out_valid_next = 1'b0;
            phase_next     = 1'b0;
        end
        else if (pop_fire)
        begin
            phase_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_evt_reg <= q_evt;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            phase_reg     <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            phase_reg     <= phase_next;
        end
    end

    `SWBD_ASSERT_NEXT(a_sync_second_beat, clk, rst_n, pop_fire && is_sync && !phase_reg, !empty && phase_reg && is_sync)
    `SWBD_ASSERT_IMPL(a_phase_only_sync, clk, rst_n, phase_reg, out_valid_reg && out_evt_reg.is_sync)
    `SWBD_ASSERT_NEXT(a_hold_unpopped, clk, rst_n, out_valid_reg && !pop, out_valid_reg && $stable(phase_reg))

endmodule

/* hdl/sync_word_byte_deserializer_core.sv */
// Top level of the sync word byte deserializer.
//
// Input channel: one serial bit per beat on bit_in, taken at a clock edge
// where push is high and full is low. Bits shift into a SYNC_WIDTH-bit
// history; a match against the sync word locks the deserializer and yields
// two result beats (high byte then low byte, is_sync set). While locked,
// every eighth bit completes an MSB-first data byte and yields one beat.
// The last output marks the final beat caused by one input bit.
// Result channel: a beat is presented while empty is low and taken when pop
// is high. An accepted bit's event passes through the queue and then the
// output register before its first result beat shows. Bits are accepted one
// per cycle while full is low; the front end classifies each bit
// combinationally and writes at most one event into a small queue, and the
// result stage drains one beat per cycle while pop is high, so only a sync
// match occupies the result port for two beats.
// When the receiver stalls, events collect in the queue; full rises once it holds QUEUE_DEPTH events,
// and input stops until room frees up. Write the sync word through
// sync_word_we/sync_word only while idle; the block does not enforce this.
// Reset clears the history, lock, byte assembly and queue, and loads the sync word with 16'hABBA.
module sync_word_byte_deserializer_core #(
    parameter int SYNC_WIDTH  = swbd_pkg::SWBD_SYNC_WIDTH,
    parameter int QUEUE_DEPTH = swbd_pkg::SWBD_QUEUE_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        sync_word_we,
    input  logic [15:0] sync_word,
    input  logic        push,
    output logic        full,
    input  logic        bit_in,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  byte_out,
    output logic        is_sync,
    output logic        last
);
    import swbd_pkg::*;

    // Bit accepted from the serial side this cycle.
    logic      accept;
    // Event produced by the front end and the queue head seen by the back end.
    logic      evt_wr;
    swbd_evt_t evt;
    swbd_evt_t q_evt;
    logic      q_valid;
    logic      q_rd;

    assign accept = push && !full;

    swbd_front #(
        .SYNC_WIDTH (SYNC_WIDTH)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .sync_word_we (sync_word_we),
        .sync_word    (sync_word),
        .accept       (accept),
        .bit_in       (bit_in),
        .evt_wr       (evt_wr),
        .evt          (evt)
    );

    // Full is driven straight from the queue count, so a bit is only taken
    // when its event, if any, is sure to fit.
    swbd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (evt_wr),
        .wr_evt    (evt),
        .rd_en     (q_rd),
        .rd_evt    (q_evt),
        .not_empty (q_valid),
        .full      (full)
    );

    // The result stage owns the output register and splits sync events
    // into their two byte beats.
    swbd_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_evt    (q_evt),
        .q_valid  (q_valid),
        .q_rd     (q_rd),
        .pop      (pop),
        .empty    (empty),
        .byte_out (byte_out),
        .is_sync  (is_sync),
        .last     (last)
    );

endmodule

/* verif/swbd_byte_checker.sv */
`timescale 1ns / 100ps
// Result checker for the sync word byte deserializer: predicts each result beat and compares it.
module swbd_byte_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        sync_word_we,
    input  logic [15:0] sync_word,
    input  logic        push,
    input  logic        full,
    input  logic        bit_in,
    input  logic        empty,
    input  logic        pop,
    input  logic [7:0]  byte_out,
    input  logic        is_sync,
    input  logic        last,
    output int          errors,
    output int          outstanding
);
    import swbd_pkg::*;

    typedef struct {
        logic [SWBD_BYTE_W-1:0] data;
        logic                   sync_half;
        logic                   final_beat;
    } beat_t;

    beat_t expected_beats[$];

    // Shadow copy of the deserializer state.
    logic [SWBD_SYNC_WIDTH-1:0] history;
    logic                       locked;
    logic [SWBD_BYTE_W-1:0]     accum;
    logic [2:0]                 fill;
    logic [SWBD_WORD_W-1:0]     pattern;
    int                         error_tally;

    function automatic void queue_beat(input logic [7:0] data, input logic sync_half,
                                       input logic final_beat);
        beat_t beat;
        beat.data       = data;
        beat.sync_half  = sync_half;
        beat.final_beat = final_beat;
        expected_beats.push_back(beat);
    endfunction

    // Shifts one bit in and queues the beats that it causes.
    function automatic void deserialize_bit(input logic b);
        longint unsigned hist_wide;
        history   = {history[SWBD_SYNC_WIDTH-2:0], b};
        hist_wide = 64'(history);
        if (hist_wide == 64'(pattern)) begin
            // A match locks or realigns; the matching bit is not data.
            locked = 1'b1;
            accum  = '0;
            fill   = '0;
            queue_beat(hist_wide[15:8], 1'b1, 1'b0);
            queue_beat(hist_wide[7:0], 1'b1, 1'b1);
        end
        else if (locked) begin
            accum = accum | (8'(b) << (SWBD_BIT_TOP - fill));
            if (fill == SWBD_BIT_TOP) begin
                queue_beat(accum, 1'b0, 1'b1);
                accum = '0;
                fill  = '0;
            end
            else begin
                fill = fill + 3'd1;
            end
        end
    endfunction

    always @(posedge clk or negedge rst_n) begin
        beat_t oldest;
        if (!rst_n) begin
            history     = '0;
            locked      = 1'b0;
            accum       = '0;
            fill        = '0;
            pattern     = SWBD_SYNC_RESET;
            error_tally = 0;
            expected_beats.delete();
            errors      <= 0;
            outstanding <= 0;
        end
        else begin
            if (sync_word_we) begin
                pattern = sync_word;
            end
            // Results are compared before the new bit is predicted, since a bit
            // cannot produce a beat at the edge where it is taken.
            if (pop && !empty) begin
                if (expected_beats.size() == 0) begin
                    $display("%0t: unexpected beat byte=%02h is_sync=%b last=%b",
                             $time, byte_out, is_sync, last);
                    error_tally++;
                end
                else begin
                    oldest = expected_beats.pop_front();
                    if (byte_out !== oldest.data || is_sync !== oldest.sync_half ||
                        last !== oldest.final_beat) begin
                        $display({"%0t: mismatch expected byte=%02h is_sync=%b last=%b,",
                                  " actual byte=%02h is_sync=%b last=%b"},
                                 $time, oldest.data, oldest.sync_half, oldest.final_beat,
                                 byte_out, is_sync, last);
                        error_tally++;
                    end
                end
            end
            if (push && !full) begin
                deserialize_bit(bit_in);
            end
            errors      <= error_tally;
            outstanding <= expected_beats.size();
        end
    end

endmodule

/* verif/sync_word_byte_deserializer_core_tb.sv */
`timescale 1ns / 100ps
// Testbench top for the sync word byte deserializer: stimulus, handshake idling and verdict.
module sync_word_byte_deserializer_core_tb;

    import swbd_pkg::*;

    // Number of bits sent under each sync word setting.
    localparam int PHASE_BITS    = 200;
    // Settle time after the result side drains, before the sync word is changed.
    localparam int SETTLE_CYCLES = 4;
    localparam int END_CYCLES    = 10;
    // Watchdog limit, well above the longest legal quiet stretch.
    localparam int STALL_LIMIT   = 1000;

    logic        clk;
    logic        rst_n;
    logic        sync_word_we;
    logic [15:0] sync_word;
    logic        push;
    logic        full;
    logic        bit_in;
    logic        empty;
    logic        pop;
    logic [7:0]  byte_out;
    logic        is_sync;
    logic        last;

    int          errors;
    int          outstanding;
    int          bits_sent;
    int          idle_cycles;
    logic [15:0] active_sync;

    sync_word_byte_deserializer_core u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .sync_word_we(sync_word_we),
        .sync_word   (sync_word),
        .push        (push),
        .full        (full),
        .bit_in      (bit_in),
        .empty       (empty),
        .pop         (pop),
        .byte_out    (byte_out),
        .is_sync     (is_sync),
        .last        (last)
    );

    // The checker watches both channels and the register port on its own.
    swbd_byte_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .sync_word_we(sync_word_we),
        .sync_word   (sync_word),
        .push        (push),
        .full        (full),
        .bit_in      (bit_in),
        .empty       (empty),
        .pop         (pop),
        .byte_out    (byte_out),
        .is_sync     (is_sync),
        .last        (last),
        .errors      (errors),
        .outstanding (outstanding)
    );

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Gap after an input beat. Most beats follow back to back or after a short
    // pause; a few wait long. A dense segment never pauses at all.
    function automatic int pick_gap(input bit dense);
        int r;
        r = $urandom_range(0, 99);
        if (dense || r < 65) begin
            return 0;
        end
        else if (r < 95) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // Length of a receiver stall, mostly short with the odd long one.
    function automatic int pick_stall();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) begin
            return $urandom_range(1, 3);
        end
        else if (r < 95) begin
            return $urandom_range(4, 8);
        end
        return $urandom_range(10, 30);
    endfunction

    // Presents one bit and holds it until the block takes it. When no gap
    // follows, push stays high so that the next bit is offered straight away.
    task automatic drive_bit(input logic b, input int gap);
        push   <= 1'b1;
        bit_in <= b;
        do @(posedge clk); while (full);
        bits_sent++;
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Sends a sixteen-bit pattern, most significant bit first.
    task automatic drive_word(input logic [15:0] word, input bit dense);
        for (int i = 15; i >= 0; i--) begin
            drive_bit(word[i], pick_gap(dense));
        end
    endtask

    // A well-formed frame: the sync word and then a run of data bytes.
    task automatic send_frame(input bit dense);
        int          nbytes;
        logic [7:0]  data;
        nbytes = ($urandom_range(0, 9) < 9) ? $urandom_range(0, 4) : $urandom_range(5, 12);
        drive_word(active_sync, dense);
        repeat (nbytes) begin
            data = 8'($urandom_range(0, 255));
            for (int i = 7; i >= 0; i--) begin
                drive_bit(data[i], pick_gap(dense));
            end
        end
    endtask

    // Line noise of random length.
    task automatic send_noise(input bit dense);
        repeat ($urandom_range(1, 24)) begin
            drive_bit(1'($urandom_range(0, 1)), pick_gap(dense));
        end
    endtask

    // The sync word with one bit flipped, which should not lock on its own.
    task automatic send_broken_sync(input bit dense);
        drive_word(active_sync ^ (16'h0001 << $urandom_range(0, 15)), dense);
    endtask

    // Stops the sender and waits until every predicted beat has come out,
    // then lets the pipeline settle in case a bit is still being classified.
    task automatic drain_results();
        push <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Register writes happen only after a drain, while the block is idle.
    task automatic write_sync(input logic [15:0] value);
        sync_word_we <= 1'b1;
        sync_word    <= value;
        active_sync   = value;
        @(posedge clk);
        sync_word_we <= 1'b0;
    endtask

    // Random mix of segments under the current sync word. Frames dominate so
    // that the block spends most of its time locked and assembling bytes.
    task automatic run_phase();
        int  phase_start;
        int  r;
        bit  dense;
        phase_start = bits_sent;
        while (bits_sent - phase_start < PHASE_BITS) begin
            r     = $urandom_range(0, 9);
            dense = ($urandom_range(0, 4) == 0);
            if (r < 6) begin
                send_frame(dense);
            end
            else if (r < 8) begin
                send_noise(dense);
            end
            else begin
                send_broken_sync(dense);
            end
        end
    endtask

    // Receiver: bursts of pop alternate with stalls, and now and then a long
    // burst keeps the result side drained with no idling at all.
    initial begin
        pop <= 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever begin
            pop <= 1'b1;
            if ($urandom_range(0, 4) == 0) begin
                repeat ($urandom_range(20, 60)) @(posedge clk);
            end
            else begin
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
            pop <= 1'b0;
            repeat (pick_stall()) @(posedge clk);
        end
    end

    // Watchdog: ends the run when neither channel moves a beat for too long.
    always @(posedge clk) begin
        if (!rst_n) begin
            idle_cycles <= 0;
        end
        else if ((push && !full) || (pop && !empty)) begin
            idle_cycles <= 0;
        end
        else if (idle_cycles + 1 >= STALL_LIMIT) begin
            $display("%0t: no beat accepted for %0d cycles", $time, STALL_LIMIT);
            $display("Verification failed");
            $finish;
        end
        else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        logic [7:0] first_byte;
        rst_n        <= 1'b0;
        sync_word_we <= 1'b0;
        sync_word    <= '0;
        push         <= 1'b0;
        bit_in       <= 1'b0;
        bits_sent     = 0;
        active_sync   = SWBD_SYNC_RESET;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed opening under the reset sync word: the first fifteen bits
        // arrive before lock and emit nothing, the sixteenth locks and emits
        // both halves, then eight data bits complete one byte.
        first_byte = 8'hC5;
        drive_word(active_sync, 1'b1);
        for (int i = 7; i >= 0; i--) begin
            drive_bit(first_byte[i], 0);
        end

        // Random part, first still under the reset sync word.
        run_phase();

        // The all-zero and all-one extremes, then two random settings. Each
        // change waits for the result side to empty completely.
        drain_results();
        write_sync(16'h0000);
        run_phase();
        drain_results();
        write_sync(16'hFFFF);
        run_phase();
        drain_results();
        write_sync(16'($urandom_range(0, 16'hFFFF)));
        run_phase();
        drain_results();
        write_sync(16'($urandom_range(0, 16'hFFFF)));
        run_phase();

        // Wind down: wait for the last beats, then give stragglers a chance to
        // show up as unexpected results.
        push <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
        repeat (END_CYCLES) @(posedge clk);

        if (errors == 0 && outstanding == 0) begin
            $display("Verification passed");
        end
        else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
